### rtl/bdc_pkg.sv
// Shared types, codes and helpers for the button debounce and click counter.
`timescale 1ns / 1ps

package bdc_pkg;

    // Field widths
    localparam int CountW   = 16;
    localparam int InDataW  = 24;   // pin_level + min_hold, padded to bytes
    localparam int OutDataW = 40;   // pressed + hold + count + hit, padded to bytes
    localparam int CfgIdxW  = 8;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TICKS = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_CLICK_WINDOW   = 8'd1;

    // Reset values of the configuration registers
    localparam logic [CountW-1:0] DebounceTicksRst = 16'd50;
    localparam logic [CountW-1:0] ClickWindowRst   = 16'd500;

    // Request kinds carried in tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // Button phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2
    } phase_t;

    // One input word after unpacking
    typedef struct packed {
        logic              req_type;
        logic              pin_level;
        logic [CountW-1:0] min_hold;
    } item_t;

    // Timing configuration
    typedef struct packed {
        logic [CountW-1:0] debounce_ticks;
        logic [CountW-1:0] click_window_ticks;
    } cfg_t;

    // Saturating increment of a 16-bit counter
    function automatic logic [CountW-1:0] sat_inc16(input logic [CountW-1:0] v);
        logic [CountW-1:0] r;
        if (v == CountMax)
        begin
            r = v;
        end
        else
        begin
            r = v + 16'd1;
        end
        return r;
    endfunction

endpackage

### rtl/bdc_cfg_regs.sv
// Configuration registers for debounce and click window timing.
`timescale 1ns / 1ps

module bdc_cfg_regs
    import bdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CountW-1:0]  cfg_data,
    output cfg_t               cfg
);

    logic [CountW-1:0] debounce_reg;
    logic [CountW-1:0] window_reg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DebounceTicksRst;
            window_reg   <= ClickWindowRst;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_reg <= cfg_data;
                REG_CLICK_WINDOW:   window_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.debounce_ticks     = debounce_reg;
    assign cfg.click_window_ticks = window_reg;

endmodule

### rtl/bdc_in_stage.sv
// Input register that captures one request word from the slave stream.
`timescale 1ns / 1ps

module bdc_in_stage
    import bdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [InDataW-1:0] s_tdata,
    input  logic [0:0]         s_tuser,
    input  logic               out_free,
    output logic               item_valid,
    output item_t              item
);

    logic  valid_reg;
    item_t item_reg;
    logic  advance;
    logic  load;

    // Word moves on when the result side has room
    assign advance  = valid_reg && out_free;
    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.req_type  <= s_tuser[0];
            item_reg.pin_level <= s_tdata[0];
            item_reg.min_hold  <= s_tdata[CountW:1];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/bdc_engine.sv
// Button state update and result register.
`timescale 1ns / 1ps

module bdc_engine
    import bdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                item_valid,
    input  item_t               item,
    output logic                out_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata
);

    phase_t            phase_reg,  phase_next;
    logic              flag_reg,   flag_next;
    logic [CountW-1:0] hold_reg,   hold_next;
    logic [CountW-1:0] click_reg,  click_next;
    logic [CountW-1:0] deb_reg,    deb_next;
    logic [CountW-1:0] win_reg,    win_next;
    logic              run_reg,    run_next;
    logic              hit_next;
    logic              mvalid_reg, mvalid_next;
    logic [OutDataW-1:0] mdata_reg;

    logic              take;
    logic              low;
    logic              win_started;
    logic [CountW-1:0] deb_inc;
    logic [CountW-1:0] win_inc;

    assign out_free = !mvalid_reg || m_tready;
    assign take     = item_valid && out_free;
    assign low      = !item.pin_level;
    assign deb_inc  = sat_inc16(deb_reg);
    assign win_inc  = sat_inc16(win_reg);

    // Next state for one word
    always_comb
    begin
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        hold_next   = hold_reg;
        click_next  = click_reg;
        deb_next    = deb_reg;
        win_next    = win_reg;
        run_next    = run_reg;
        hit_next    = 1'b0;
        win_started = 1'b0;

        if (item.req_type == REQ_TICK)
        begin
            case (phase_reg)
                PH_DEBOUNCE:
                begin
                    deb_next = deb_inc;
                    if (deb_inc >= cfg.debounce_ticks)
                    begin
                        deb_next = '0;
                        if (low)
                        begin
                            hold_next  = '0;
                            flag_next  = 1'b1;
                            click_next = sat_inc16(click_reg);
                            phase_next = PH_HOLD;
                        end
                        else
                        begin
                            flag_next  = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_HOLD:
                begin
                    if (low)
                    begin
                        hold_next = sat_inc16(hold_reg);
                    end
                    else
                    begin
                        flag_next = 1'b0;
                        hold_next = '0;
                        // first release of a series opens the click window
                        if (click_reg == 16'd1)
                        begin
                            win_next    = '0;
                            run_next    = 1'b1;
                            win_started = 1'b1;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (low)
                    begin
                        deb_next   = '0;
                        phase_next = PH_DEBOUNCE;
                    end
                end
            endcase

            // Advance the click window; expiry clears the series
            if (run_reg && !win_started)
            begin
                win_next = win_inc;
                if (win_inc >= cfg.click_window_ticks)
                begin
                    run_next   = 1'b0;
                    win_next   = '0;
                    click_next = '0;
                end
            end
        end
        else
        begin
            // Consume the press once it has been held long enough
            if (flag_reg && (hold_reg >= item.min_hold))
            begin
                flag_next = 1'b0;
                hit_next  = 1'b1;
            end
        end
    end

    // Output valid: set on a taken word, drop when the consumer takes it
    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (take)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            flag_reg   <= 1'b0;
            hold_reg   <= '0;
            click_reg  <= '0;
            deb_reg    <= '0;
            win_reg    <= '0;
            run_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            mvalid_reg <= mvalid_next;
            if (take)
            begin
                phase_reg <= phase_next;
                flag_reg  <= flag_next;
                hold_reg  <= hold_next;
                click_reg <= click_next;
                deb_reg   <= deb_next;
                win_reg   <= win_next;
                run_reg   <= run_next;
            end
        end
    end

    // Result word: pressed, hold_ticks, press_count, check_hit
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mdata_reg <= {6'd0, hit_next, click_next, hold_next, flag_next};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

### rtl/button_debounce_click_counter_top.sv
// Top level of the active-low push-button debouncer with click counting.
`timescale 1ns / 1ps

// Qualifies an active-low push button. Each tick word (tuser = 0) brings one
// pin sample and counts as one millisecond; a check word (tuser = 1) consumes
// a confirmed press once it has been held for min_hold ticks. Every word
// gives exactly one result word. The block takes one word per clock cycle
// while the result side is not stalled; a word passes through the input
// register and then the state/result register. s_tready follows m_tready
// combinationally through both stages. Configuration writes are taken every
// cycle (cfg_ready is tied high) and should be made while no word is in
// flight.
module button_debounce_click_counter_top
    import bdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // [0] pin_level, [16:1] min_hold, rest zero
    input  logic [0:0]          s_tuser,   // [0] req_type
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // [0] pressed, [16:1] hold_ticks,
                                           // [32:17] press_count, [33] check_hit
    // Configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CountW-1:0]   cfg_data
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  out_free;

    assign cfg_ready = 1'b1;

    bdc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .out_free   (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    bdc_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### rtl/bdc_checker.sv
// Port-level checks for the button debouncer, bound to the top level.
`timescale 1ns / 1ps

module bdc_checker
    import bdc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    // A successful check always consumes the press
    a_hit_clears_press: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[33]) |-> !m_tdata[0])
        else $error("check_hit with pressed still set");

    // Empty result side never stalls the request side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low while result register empty");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    // A new result follows only an accepted request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid && !s_tvalid) |=> !m_tvalid || $past(s_tvalid && s_tready, 2)
            || $past(s_tvalid, 1))
        else $error("result word without a request");

endmodule

bind button_debounce_click_counter_top bdc_checker u_bdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/click_counter_checker.sv
// Checker for the button debouncer: predicts every result word and compares it with the DUT.
`timescale 1ns / 1ps

module click_counter_checker
    import bdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,     // [0] pin_level, [16:1] min_hold
    input  logic [0:0]          s_tuser,     // [0] req_type
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OutDataW-1:0] m_tdata,     // [0] pressed, [16:1] hold_ticks,
                                             // [32:17] press_count, [33] check_hit
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CountW-1:0]   cfg_data,
    output int                  failures,
    output int                  outstanding,
    output int                  results,
    output int                  hits
);

    // Keep the log readable when the design is badly off
    localparam int ReportCap = 100;

    typedef struct packed {
        logic              pressed;
        logic [CountW-1:0] hold_ticks;
        logic [CountW-1:0] press_count;
        logic              check_hit;
    } button_status_t;

    // Timing registers as the design should see them
    logic [CountW-1:0] debounce_limit;
    logic [CountW-1:0] window_limit;

    // Button state
    phase_t            btn_phase;
    logic              press_latched;
    logic [CountW-1:0] held;
    logic [CountW-1:0] clicks;
    logic [CountW-1:0] settle_cnt;
    logic [CountW-1:0] window_cnt;
    logic              window_open;

    button_status_t    expected_status[$];

    function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] v);
        return (v == CountMax) ? v : v + 1'b1;
    endfunction

    // Advance the button state by one millisecond tick
    task automatic sample_pin(input logic low);
        logic opened;
        opened = 1'b0;
        case (btn_phase)
            PH_DEBOUNCE:
            begin
                settle_cnt = bump(settle_cnt);
                if (settle_cnt >= debounce_limit)
                begin
                    settle_cnt = '0;
                    if (low)
                    begin
                        held          = '0;
                        press_latched = 1'b1;
                        clicks        = bump(clicks);
                        btn_phase     = PH_HOLD;
                    end
                    else
                    begin
                        press_latched = 1'b0;
                        btn_phase     = PH_IDLE;
                    end
                end
            end
            PH_HOLD:
            begin
                if (low)
                begin
                    held = bump(held);
                end
                else
                begin
                    press_latched = 1'b0;
                    held          = '0;
                    // first release of a series opens the click window
                    if (clicks == 16'd1)
                    begin
                        window_cnt  = '0;
                        window_open = 1'b1;
                        opened      = 1'b1;
                    end
                    btn_phase = PH_IDLE;
                end
            end
            default:
            begin
                btn_phase = PH_IDLE;
                if (low)
                begin
                    settle_cnt = '0;
                    btn_phase  = PH_DEBOUNCE;
                end
            end
        endcase

        // Run the click window, clear the series when it expires
        if (window_open && !opened)
        begin
            window_cnt = bump(window_cnt);
            if (window_cnt >= window_limit)
            begin
                window_open = 1'b0;
                window_cnt  = '0;
                clicks      = '0;
            end
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            failures++;
            if (failures <= ReportCap)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            end
        end
    endtask

    // Watch all three channels at each rising edge
    always @(posedge clk)
    begin : watch
        button_status_t got;
        button_status_t want;
        logic           hit;
        if (!rst_n)
        begin
            debounce_limit = DebounceTicksRst;
            window_limit   = ClickWindowRst;
            btn_phase      = PH_IDLE;
            press_latched  = 1'b0;
            held           = '0;
            clicks         = '0;
            settle_cnt     = '0;
            window_cnt     = '0;
            window_open    = 1'b0;
            expected_status.delete();
            failures       = 0;
            outstanding    = 0;
            results        = 0;
            hits           = 0;
        end
        else
        begin
            // Track register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DEBOUNCE_TICKS)
                begin
                    debounce_limit = cfg_data;
                end
                else if (cfg_index == REG_CLICK_WINDOW)
                begin
                    window_limit = cfg_data;
                end
            end

            // Predict the result of an accepted request word
            if (s_tvalid && s_tready)
            begin
                hit = 1'b0;
                if (s_tuser[0] == REQ_TICK)
                begin
                    sample_pin(~s_tdata[0]);
                end
                else if (press_latched && held >= s_tdata[16:1])
                begin
                    press_latched = 1'b0;
                    hit           = 1'b1;
                end
                expected_status.push_back('{press_latched, held, clicks, hit});
            end

            // Compare an accepted result word with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                results++;
                got = '{m_tdata[0], m_tdata[16:1], m_tdata[32:17], m_tdata[33]};
                if (got.check_hit)
                begin
                    hits++;
                end
                if (expected_status.size() == 0)
                begin
                    failures++;
                    if (failures <= ReportCap)
                    begin
                        $display("%0t: unexpected result word: expected none, actual 0x%h",
                                 $time, m_tdata);
                    end
                end
                else
                begin
                    want = expected_status.pop_front();
                    compare_field("pressed", want.pressed, got.pressed);
                    compare_field("hold_ticks", want.hold_ticks, got.hold_ticks);
                    compare_field("press_count", want.press_count, got.press_count);
                    compare_field("check_hit", want.check_hit, got.check_hit);
                    compare_field("tdata padding", 0, m_tdata[OutDataW-1:34]);
                end
            end

            outstanding = expected_status.size();
        end
    end

endmodule

### bench/testbench.sv
// Top of the debouncer bench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module testbench;
    import bdc_pkg::*;

    localparam int ClkPeriod     = 10;
    localparam int RunLimit      = 2_000_000;
    localparam int HoldOffCycles = 200;
    localparam int SessionWords  = 130;

    localparam logic PinDown = 1'b0;
    localparam logic PinUp   = 1'b1;

    // Indexes with no register behind them
    localparam logic [CfgIdxW-1:0] RegUnused = 8'd2;
    localparam logic [CfgIdxW-1:0] RegTop    = 8'hFF;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;   // [0] pin_level, [16:1] min_hold
    logic [0:0]          s_tuser   = '0;   // [0] req_type
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OutDataW-1:0] m_tdata;           // [0] pressed, [16:1] hold_ticks,
                                            // [32:17] press_count, [33] check_hit
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CountW-1:0]   cfg_data  = '0;

    int failures;
    int outstanding;
    int results;
    int hits;

    int unsigned cycle_count   = 0;
    int          words_sent    = 0;
    int          checks_sent   = 0;
    int          settings_used = 1;

    logic [CountW-1:0] settle_now = DebounceTicksRst;
    logic [CountW-1:0] window_now = ClickWindowRst;

    bit quiet        = 1'b0;
    bit squeeze_due  = 1'b0;
    bit squeeze_done = 1'b0;
    bit rx_holding   = 1'b0;

    int unsigned settle_set[6] = '{0, 1, 2, 5, 3, 7};
    int unsigned window_set[6] = '{0, 1, 6, 0, 65535, 25};

    always #(ClkPeriod / 2) clk = ~clk;

    button_debounce_click_counter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    click_counter_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding),
        .results     (results),
        .hits        (hits)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RunLimit)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Pace the result side: random ready runs, one long hold-off on request
    always
    begin : rx_pace
        int run;
        @(posedge clk);
        if (squeeze_due && !squeeze_done)
        begin
            rx_holding = 1'b1;
            m_tready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clk);
            rx_holding   = 1'b0;
            squeeze_done = 1'b1;
        end
        else if (quiet)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            run = $urandom_range(0, 99);
            if (run < 70)
            begin
                m_tready <= 1'b1;
                run = $urandom_range(1, 20);
            end
            else if (run < 95)
            begin
                m_tready <= 1'b0;
                run = $urandom_range(1, 4);
            end
            else
            begin
                m_tready <= 1'b0;
                run = $urandom_range(10, 40);
            end
            repeat (run - 1) @(posedge clk);
        end
    end

    // Idle cycles before the next request word: mostly none, a few long
    function automatic int pick_gap();
        int r;
        if (quiet || rx_holding)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one request word and hold it until taken; call at a rising edge
    task automatic send_word(input logic kind, input logic level, input logic [CountW-1:0] need);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(InDataW - CountW - 1){1'b0}}, need, level};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // A tick carries a random min_hold, which the block must ignore
    task automatic tick(input logic level);
        send_word(REQ_TICK, level, 16'($urandom));
    endtask

    // A check carries a random pin level, which the block must ignore
    task automatic check(input logic [CountW-1:0] need);
        checks_sent++;
        send_word(REQ_CHECK, 1'($urandom_range(0, 1)), need);
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == REG_DEBOUNCE_TICKS)
        begin
            settle_now = val;
        end
        else if (idx == REG_CLICK_WINDOW)
        begin
            window_now = val;
        end
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [CountW-1:0] settle, input logic [CountW-1:0] window);
        write_reg(REG_DEBOUNCE_TICKS, settle);
        write_reg(REG_CLICK_WINDOW, window);
        settings_used++;
    endtask

    // Random click series sized to the current timing, with some noise and bounce
    task automatic run_session(input int words);
        int stop_at;
        int clicks;
        int len;
        int gap;
        int r;
        bit bouncy;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                // noise: arbitrary words
                repeat ($urandom_range(1, 6))
                begin
                    send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              16'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(0, 3)) tick(PinUp);
                clicks = $urandom_range(1, 4);
                for (int c = 0; c < clicks; c++)
                begin
                    // low stretch long enough to confirm, unless it bounces
                    bouncy = ($urandom_range(0, 4) == 0);
                    len    = 1 + ((settle_now > 1) ? int'(settle_now) : 1);
                    if (bouncy)
                    begin
                        len = $urandom_range(1, len + 2);
                    end
                    else
                    begin
                        len = len + $urandom_range(0, 10);
                    end
                    for (int i = 0; i < len; i++)
                    begin
                        if (bouncy && i > 0)
                        begin
                            tick(1'($urandom_range(0, 1)));
                        end
                        else
                        begin
                            tick(PinDown);
                        end
                        if ($urandom_range(0, 4) == 0)
                        begin
                            r = $urandom_range(0, 3);
                            check(r == 0 ? 16'd0 :
                                  (r == 3 ? 16'($urandom) : 16'($urandom_range(0, 12))));
                        end
                    end
                    // release: sometimes outlast the click window
                    if (window_now <= 64 && $urandom_range(0, 2) == 0)
                    begin
                        gap = int'(window_now) + $urandom_range(1, 3);
                    end
                    else
                    begin
                        gap = $urandom_range(1, 12);
                    end
                    repeat (gap) tick(PinUp);
                end
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Click series at the reset timing
        run_session(100);
        wait_drained();

        // Directed: one-tick debounce, two-tick window, unknown indexes ignored
        set_timing(16'd1, 16'd2);
        write_reg(RegUnused, 16'($urandom));
        write_reg(RegTop, 16'($urandom));
        check(16'd0);                                // nothing pressed yet
        tick(PinUp);
        tick(PinDown);                               // start debounce
        tick(PinDown);                               // confirm press
        check(CountMax);                             // hold too short
        tick(PinDown);
        check(16'd1);                                // consume press
        check(16'd0);                                // already consumed
        send_word(REQ_TICK, PinDown, CountMax);      // min_hold ignored on ticks
        tick(PinUp);                                 // first release opens window
        tick(PinDown);
        tick(PinDown);                               // second press as window closes
        tick(PinUp);
        tick(PinDown);
        tick(PinUp);                                 // bounce rejected at re-sample
        check(16'd0);
        wait_drained();

        // Directed: zero debounce and zero window
        set_timing(16'd0, 16'd0);
        tick(PinDown);
        tick(PinDown);
        tick(PinUp);                                 // window opens
        tick(PinUp);                                 // and closes on the next tick
        check(16'd0);

        // Random sessions over several timing settings
        for (int s = 0; s < 7; s++)
        begin
            wait_drained();
            if (s < 6)
            begin
                set_timing(16'(settle_set[s]), 16'(window_set[s]));
            end
            else
            begin
                set_timing(16'($urandom_range(0, 8)), 16'($urandom_range(0, 30)));
            end
            quiet = (s % 3 == 2);
            if (s == 3)
            begin
                squeeze_due = 1'b1;
            end
            run_session(SessionWords);
        end

        // Longest timing: a debounce wait that stays open over a long low stretch
        wait_drained();
        set_timing(CountMax, CountMax);
        quiet = 1'b1;
        tick(PinUp);
        repeat (100) tick(PinDown);
        check(16'd0);
        tick(PinUp);
        check(16'd0);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Run covered %0d request words (%0d hold checks) and %0d result words,",
                 words_sent, checks_sent, results);
        $display("%0d checks consumed a press; %0d timing settings from 0 to 65535.",
                 hits, settings_used);
        if (failures == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
